// File: rtl/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types and constants of the path bounds accumulator.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int NUM_LANES = 3;
    localparam int COORD_W   = 32;
    localparam int OP_W      = 4;

    typedef logic signed [COORD_W-1:0] coord_t;

    // Path command codes. Codes above OP_ELLIPSE act as no-ops.
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR   = 4'd0,
        OP_NOP     = 4'd1,
        OP_POINT   = 4'd2,
        OP_QUAD    = 4'd3,
        OP_CUBIC   = 4'd4,
        OP_ARCTO   = 4'd5,
        OP_CIRCLE  = 4'd6,
        OP_RECT    = 4'd7,
        OP_ELLIPSE = 4'd8
    } op_t;

    // What one lane makes of its operands.
    typedef enum logic [1:0] {
        LANE_OFF,
        LANE_PASS,
        LANE_ADD,
        LANE_SUB
    } lane_mode_t;

    typedef struct packed {
        lane_mode_t mode;
        coord_t     px;
        coord_t     py;
        coord_t     qx;
        coord_t     qy;
    } lane_cmd_t;

    typedef struct packed {
        logic   valid;
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        logic   any;
        coord_t lo_x;
        coord_t hi_x;
        coord_t lo_y;
        coord_t hi_y;
    } box_t;

endpackage

// File: rtl/pba_lane.sv
// ----------------------------------------------------------------------------
// pba_lane
// One point lane: passes a point or forms a saturated sum or difference,
// and registers the result.
// ----------------------------------------------------------------------------
module pba_lane
    import pba_pkg::*;
(
    input  logic      aclk,
    input  logic      load,
    input  lane_cmd_t cmd,
    output point_t    point
);

    point_t point_reg;
    point_t point_next;

    // Clamp a 33-bit signed sum to the signed 32-bit range.
    function automatic coord_t sat32(input logic signed [COORD_W:0] s);
        coord_t r;
        if (s[COORD_W] != s[COORD_W-1]) begin
            r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end else begin
            r = s[COORD_W-1:0];
        end
        return r;
    endfunction

    logic signed [COORD_W:0] ext_px;
    logic signed [COORD_W:0] ext_py;
    logic signed [COORD_W:0] ext_qx;
    logic signed [COORD_W:0] ext_qy;

    assign ext_px = {cmd.px[COORD_W-1], cmd.px};
    assign ext_py = {cmd.py[COORD_W-1], cmd.py};
    assign ext_qx = {cmd.qx[COORD_W-1], cmd.qx};
    assign ext_qy = {cmd.qy[COORD_W-1], cmd.qy};

    always_comb begin
        point_next.valid = 1'b1;
        point_next.x     = cmd.px;
        point_next.y     = cmd.py;
        case (cmd.mode)
            LANE_PASS: begin
                point_next.x = cmd.px;
                point_next.y = cmd.py;
            end
            LANE_ADD: begin
                point_next.x = sat32(ext_px + ext_qx);
                point_next.y = sat32(ext_py + ext_qy);
            end
            LANE_SUB: begin
                point_next.x = sat32(ext_px - ext_qx);
                point_next.y = sat32(ext_py - ext_qy);
            end
            default: begin
                point_next.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

// File: rtl/pba_merge.sv
// ----------------------------------------------------------------------------
// pba_merge
// Combines the points that the lanes found for one command into one
// registered box.
// ----------------------------------------------------------------------------
module pba_merge
    import pba_pkg::*;
(
    input  logic   aclk,
    input  logic   load,
    input  point_t points [NUM_LANES],
    output box_t   box
);

    box_t box_reg;
    box_t box_next;

    always_comb begin
        box_next = '0;
        for (int i = 0; i < NUM_LANES; i++) begin
            if (points[i].valid) begin
                if (!box_next.any) begin
                    box_next.any  = 1'b1;
                    box_next.lo_x = points[i].x;
                    box_next.hi_x = points[i].x;
                    box_next.lo_y = points[i].y;
                    box_next.hi_y = points[i].y;
                end else begin
                    if (points[i].x < box_next.lo_x) begin
                        box_next.lo_x = points[i].x;
                    end
                    if (points[i].x > box_next.hi_x) begin
                        box_next.hi_x = points[i].x;
                    end
                    if (points[i].y < box_next.lo_y) begin
                        box_next.lo_y = points[i].y;
                    end
                    if (points[i].y > box_next.hi_y) begin
                        box_next.hi_y = points[i].y;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            box_reg <= box_next;
        end
    end

    assign box = box_reg;

endmodule

// File: rtl/path_bounds_accumulator.sv
// ----------------------------------------------------------------------------
// path_bounds_accumulator
// Running axis-aligned bounding box of a stream of vector-path commands.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake          Word
//   s_       in         s_valid/s_ready    operation, ax, ay, bx, by, cx, cy
//   m_       out        m_valid/m_ready    box x, y, width, height, is_empty
//
// One command word is accepted per cycle while s_ready is high; its result word
// is offered once it has passed the lane, merge and accumulator registers. The
// pipeline is: three point lanes (stage 1), a merge of the lane points into one
// box per command (stage 2), and the accumulator registers, which also serve as
// the output register (stage 3). The accumulator update is a single
// compare-and-select per corner, which sets the one-word-per-cycle rate. Reset is
// synchronous on aresetn and empties the box and the pipeline. When m_ready is
// low the pipeline holds; each stage still fills while a later one waits, so up
// to three words can be in flight.
//
module path_bounds_accumulator
    import pba_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [OP_W-1:0]           s_operation,
    input  logic signed [COORD_W-1:0] s_ax,
    input  logic signed [COORD_W-1:0] s_ay,
    input  logic signed [COORD_W-1:0] s_bx,
    input  logic signed [COORD_W-1:0] s_by,
    input  logic signed [COORD_W-1:0] s_cx,
    input  logic signed [COORD_W-1:0] s_cy,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [COORD_W-1:0] m_box_x,
    output logic signed [COORD_W-1:0] m_box_y,
    output logic [COORD_W-1:0]        m_box_width,
    output logic [COORD_W-1:0]        m_box_height,
    output logic                      m_is_empty
);

    // Stage enables: a stage loads when it is empty or its word moves on.
    logic load1;
    logic load2;
    logic load3;

    logic valid1_reg;
    logic valid1_next;
    logic valid2_reg;
    logic valid2_next;
    logic valid3_reg;
    logic valid3_next;

    // A clear command travels beside the lanes as a flag of its own.
    logic clear1_reg;
    logic clear2_reg;

    box_t   acc_reg;
    box_t   acc_next;

    op_t       op;
    lane_cmd_t lane_cmds [NUM_LANES];
    point_t    lane_points [NUM_LANES];
    box_t      item_box;

    assign load3 = !valid3_reg || m_ready;
    assign load2 = !valid2_reg || load3;
    assign load1 = !valid1_reg || load2;

    assign s_ready = load1;

    assign op = op_t'(s_operation);

    // Decode the command into lane work. Lane 0 takes the first point or the
    // low corner, lane 1 the second point or the high corner, and lane 2 the
    // third point of a cubic curve.
    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lane_cmds[i].mode = LANE_OFF;
            lane_cmds[i].px   = s_ax;
            lane_cmds[i].py   = s_ay;
            lane_cmds[i].qx   = s_bx;
            lane_cmds[i].qy   = s_by;
        end
        case (op)
            OP_POINT: begin
                lane_cmds[0].mode = LANE_PASS;
            end
            OP_QUAD, OP_ARCTO: begin
                lane_cmds[0].mode = LANE_PASS;
                lane_cmds[1].mode = LANE_PASS;
                lane_cmds[1].px   = s_bx;
                lane_cmds[1].py   = s_by;
            end
            OP_CUBIC: begin
                lane_cmds[0].mode = LANE_PASS;
                lane_cmds[1].mode = LANE_PASS;
                lane_cmds[1].px   = s_bx;
                lane_cmds[1].py   = s_by;
                lane_cmds[2].mode = LANE_PASS;
                lane_cmds[2].px   = s_cx;
                lane_cmds[2].py   = s_cy;
            end
            OP_CIRCLE: begin
                // A circle uses its single radius on both axes.
                lane_cmds[0].mode = LANE_SUB;
                lane_cmds[0].qy   = s_bx;
                lane_cmds[1].mode = LANE_ADD;
                lane_cmds[1].qy   = s_bx;
            end
            OP_RECT: begin
                lane_cmds[0].mode = LANE_PASS;
                lane_cmds[1].mode = LANE_ADD;
            end
            OP_ELLIPSE: begin
                lane_cmds[0].mode = LANE_SUB;
                lane_cmds[1].mode = LANE_ADD;
            end
            default: begin
                // Clear, no-op and unused codes carry no points.
            end
        endcase
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pba_lane u_lane (
            .aclk  (aclk),
            .load  (load1),
            .cmd   (lane_cmds[g]),
            .point (lane_points[g])
        );
    end

    pba_merge u_merge (
        .aclk   (aclk),
        .load   (load2),
        .points (lane_points),
        .box    (item_box)
    );

    assign valid1_next = load1 ? s_valid    : valid1_reg;
    assign valid2_next = load2 ? valid1_reg : valid2_reg;
    assign valid3_next = load3 ? valid2_reg : valid3_reg;

    // Fold the command's box into the running box. The first box after
    // reset or a clear replaces the corners outright.
    always_comb begin
        acc_next = acc_reg;
        if (load3 && valid2_reg) begin
            if (clear2_reg) begin
                acc_next = '0;
            end else if (item_box.any) begin
                if (!acc_reg.any) begin
                    acc_next = item_box;
                end else begin
                    if (item_box.lo_x < acc_reg.lo_x) begin
                        acc_next.lo_x = item_box.lo_x;
                    end
                    if (item_box.hi_x > acc_reg.hi_x) begin
                        acc_next.hi_x = item_box.hi_x;
                    end
                    if (item_box.lo_y < acc_reg.lo_y) begin
                        acc_next.lo_y = item_box.lo_y;
                    end
                    if (item_box.hi_y > acc_reg.hi_y) begin
                        acc_next.hi_y = item_box.hi_y;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
            acc_reg    <= '0;
        end else begin
            valid1_reg <= valid1_next;
            valid2_reg <= valid2_next;
            valid3_reg <= valid3_next;
            acc_reg    <= acc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load1) begin
            clear1_reg <= (op == OP_CLEAR);
        end
        if (load2) begin
            clear2_reg <= clear1_reg;
        end
    end

    // The corners hold while a result waits, so the outputs are stable.
    // Width and height always fit in 32 unsigned bits.
    assign m_valid      = valid3_reg;
    assign m_box_x      = acc_reg.any ? acc_reg.lo_x : '0;
    assign m_box_y      = acc_reg.any ? acc_reg.lo_y : '0;
    assign m_box_width  = acc_reg.any ? COORD_W'(acc_reg.hi_x - acc_reg.lo_x) : '0;
    assign m_box_height = acc_reg.any ? COORD_W'(acc_reg.hi_y - acc_reg.lo_y) : '0;
    assign m_is_empty   = !acc_reg.any;

endmodule
